// File: src/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled while in reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/md5f_pkg.sv
// types, constants and md5 helper functions of the duplicate packet filter
package md5f_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [5:0] PAD_LEN_LIMIT = 6'd56;
    localparam logic [7:0] PAD_MARK      = 8'h80;

    localparam logic [1:0] ADDR_WINDOW_LEN = 2'd0;
    localparam logic [4:0] WINDOW_RESET    = 5'd16;

    // one 512-bit block handed from the front to the back
    typedef struct packed {
        logic [15:0][31:0] words;
        logic              last_blk;
        logic [31:0]       length;
    } job_t;

    // queue status seen by the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [3:0] sel);
        logic [4:0] s;
        case (sel)
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] byte_swap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// File: src/md5f_queue.sv
// two-entry block queue between the byte front and the hash back
module md5f_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  md5f_pkg::job_t          push_job,
    input  logic                    pop,
    output md5f_pkg::job_t          head_job,
    output md5f_pkg::queue_status_t status
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    md5f_pkg::job_t      entry_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW:0]         count_reg;

    assign status.full  = (count_reg == (PW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/md5f_front.sv
// byte collector: fills 64-byte blocks and appends md5 padding at packet end
module md5f_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  logic                    in_empty,
    input  md5f_pkg::queue_status_t q_status,
    output logic                    push,
    output md5f_pkg::job_t          push_job
);

    typedef enum logic [1:0] {F_IN, F_FULL, F_PAD1, F_PAD2} fstate_t;

    fstate_t      state_reg;
    logic [31:0]  cnt_reg;
    logic         last_pend_reg;
    logic [31:0]  buf_reg [16];

    logic         take;
    logic [31:0]  cnt_inc;
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    logic [15:0][31:0] pad_words;

    assign in_ready = (state_reg == F_IN);
    assign take     = in_valid && in_ready;
    assign cnt_inc  = cnt_reg + 32'd1;
    assign fill     = cnt_reg[5:0];
    assign bit_len  = {29'd0, cnt_reg, 3'd0};
    assign push     = (state_reg != F_IN) && !q_status.full;

    // data < fill, marker at fill, length if it fits; F_PAD2: zeros, length
    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (state_reg == F_PAD2)
                begin
                    pad_words[w][8*b +: 8] = 8'd0;
                end
                else if (6'(4*w + b) < fill)
                begin
                    pad_words[w][8*b +: 8] = buf_reg[w][8*b +: 8];
                end
                else if (6'(4*w + b) == fill)
                begin
                    pad_words[w][8*b +: 8] = md5f_pkg::PAD_MARK;
                end
                else
                begin
                    pad_words[w][8*b +: 8] = 8'd0;
                end
            end
        end
        if (state_reg == F_PAD2 || fill < md5f_pkg::PAD_LEN_LIMIT)
        begin
            pad_words[14] = bit_len[31:0];
            pad_words[15] = bit_len[63:32];
        end
    end

    always_comb
    begin
        push_job.length   = cnt_reg;
        push_job.last_blk = (state_reg == F_PAD2) ||
                            (state_reg == F_PAD1 && fill < md5f_pkg::PAD_LEN_LIMIT);
        for (int w = 0; w < 16; w++)
        begin
            push_job.words[w] = (state_reg == F_FULL) ? buf_reg[w] : pad_words[w];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !in_empty)
        begin
            buf_reg[cnt_reg[5:2]][8*cnt_reg[1:0] +: 8] <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IN;
            cnt_reg       <= '0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IN:
                begin
                    if (take)
                    begin
                        if (!in_empty)
                        begin
                            cnt_reg <= cnt_inc;
                            if (cnt_inc[5:0] == 6'd0)
                            begin
                                state_reg     <= F_FULL;
                                last_pend_reg <= in_last;
                            end
                            else if (in_last)
                            begin
                                state_reg <= F_PAD1;
                            end
                        end
                        else if (in_last)
                        begin
                            state_reg <= F_PAD1;
                        end
                    end
                end
                F_FULL:
                begin
                    if (push)
                    begin
                        state_reg <= last_pend_reg ? F_PAD1 : F_IN;
                    end
                end
                F_PAD1:
                begin
                    if (push)
                    begin
                        if (fill < md5f_pkg::PAD_LEN_LIMIT)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= F_IN;
                        end
                        else
                        begin
                            state_reg <= F_PAD2;
                        end
                    end
                end
                F_PAD2:
                begin
                    if (push)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= F_IN;
                    end
                end
                default:
                begin
                    state_reg <= F_IN;
                end
            endcase
        end
    end

endmodule

// File: src/md5f_back.sv
// md5 compression, one round a cycle, then window slot update and scan
module md5f_back
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [4:0]              window_length,
    input  md5f_pkg::job_t          head_job,
    input  md5f_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_dup,
    output logic [63:0]             out_hi,
    output logic [63:0]             out_lo,
    output logic [31:0]             out_len
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    typedef enum logic [2:0] {B_IDLE, B_ROUND, B_ADD, B_WR, B_SCAN, B_DONE} bstate_t;

    bstate_t        state_reg;
    logic [5:0]     rnd_reg;
    logic [31:0]    w_reg [16];
    logic           last_reg;
    logic [31:0]    len_reg;
    logic [31:0]    ha_reg, hb_reg, hc_reg, hd_reg;
    logic [31:0]    a_reg, b_reg, c_reg, d_reg;
    logic [63:0]    hi_reg, lo_reg;
    logic           dup_reg;
    logic [CW-1:0]  ptr_reg;
    logic [CW-1:0]  rd_idx_reg;
    logic           cmp_vld_reg;
    logic           rd_vld_reg;
    logic [159:0]   rd_q_reg;
    logic [159:0]   slot_mem [WINDOW_DEPTH];
    logic           slot_vld_reg [WINDOW_DEPTH];

    logic           out_valid_reg;
    logic           out_dup_reg;
    logic [63:0]    out_hi_reg, out_lo_reg;
    logic [31:0]    out_len_reg;

    logic           win_on;
    logic [CW-1:0]  win;
    logic [CW-1:0]  ptr_inc;
    logic [CW-1:0]  ptr_next;
    logic           issue;
    logic [31:0]    f_val;
    logic [3:0]     g_idx;
    logic [31:0]    t_val;
    logic [63:0]    rot_wide;
    logic [31:0]    sum_a, sum_b, sum_c, sum_d;
    logic [159:0]   cur_key;
    logic [159:0]   rd_key;

    assign win_on   = (window_length != 5'd0) &&
                      ({27'd0, window_length} <= 32'(WINDOW_DEPTH));
    assign win      = CW'(window_length);
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_next = (ptr_inc >= win) ? '0 : ptr_inc;
    assign issue    = (state_reg == B_SCAN) && (rd_idx_reg < win);
    assign pop      = (state_reg == B_IDLE) && !q_status.empty;
    assign cur_key  = {hi_reg, lo_reg, len_reg};
    assign rd_key   = rd_vld_reg ? rd_q_reg : '0;

    assign out_valid = out_valid_reg;
    assign out_dup   = out_dup_reg;
    assign out_hi    = out_hi_reg;
    assign out_lo    = out_lo_reg;
    assign out_len   = out_len_reg;

    // round function and message word select by quarter
    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = rnd_reg[3:0];
            end
            2'd1:
            begin
                f_val = (d_reg & b_reg) | (~d_reg & c_reg);
                g_idx = 4'(5 * rnd_reg + 1);
            end
            2'd2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'(3 * rnd_reg + 5);
            end
            default:
            begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'(7 * rnd_reg);
            end
        endcase
        t_val    = a_reg + f_val + md5f_pkg::round_k(rnd_reg) + w_reg[g_idx];
        rot_wide = {t_val, t_val} << md5f_pkg::round_s({rnd_reg[5:4], rnd_reg[1:0]});
    end

    assign sum_a = ha_reg + a_reg;
    assign sum_b = hb_reg + b_reg;
    assign sum_c = hc_reg + c_reg;
    assign sum_d = hd_reg + d_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= head_job.words[i];
            end
        end
        if (state_reg == B_WR && win_on)
        begin
            slot_mem[ptr_next[IW-1:0]] <= cur_key;
        end
        if (issue)
        begin
            rd_q_reg <= slot_mem[rd_idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rnd_reg       <= '0;
            last_reg      <= 1'b0;
            len_reg       <= '0;
            ha_reg        <= md5f_pkg::INIT_A;
            hb_reg        <= md5f_pkg::INIT_B;
            hc_reg        <= md5f_pkg::INIT_C;
            hd_reg        <= md5f_pkg::INIT_D;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            dup_reg       <= 1'b0;
            ptr_reg       <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_dup_reg   <= 1'b0;
            out_hi_reg    <= '0;
            out_lo_reg    <= '0;
            out_len_reg   <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                slot_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            // drain the output register unless a new result replaces it this cycle
            if (out_valid_reg && out_ready && state_reg != B_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        last_reg  <= head_job.last_blk;
                        len_reg   <= head_job.length;
                        a_reg     <= ha_reg;
                        b_reg     <= hb_reg;
                        c_reg     <= hc_reg;
                        d_reg     <= hd_reg;
                        rnd_reg   <= '0;
                        state_reg <= B_ROUND;
                    end
                end
                B_ROUND:
                begin
                    a_reg   <= d_reg;
                    d_reg   <= c_reg;
                    c_reg   <= b_reg;
                    b_reg   <= b_reg + rot_wide[63:32];
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= B_ADD;
                    end
                end
                B_ADD:
                begin
                    if (last_reg)
                    begin
                        hi_reg    <= {md5f_pkg::byte_swap(sum_a), md5f_pkg::byte_swap(sum_b)};
                        lo_reg    <= {md5f_pkg::byte_swap(sum_c), md5f_pkg::byte_swap(sum_d)};
                        ha_reg    <= md5f_pkg::INIT_A;
                        hb_reg    <= md5f_pkg::INIT_B;
                        hc_reg    <= md5f_pkg::INIT_C;
                        hd_reg    <= md5f_pkg::INIT_D;
                        state_reg <= B_WR;
                    end
                    else
                    begin
                        ha_reg    <= sum_a;
                        hb_reg    <= sum_b;
                        hc_reg    <= sum_c;
                        hd_reg    <= sum_d;
                        state_reg <= B_IDLE;
                    end
                end
                B_WR:
                begin
                    dup_reg     <= 1'b0;
                    rd_idx_reg  <= '0;
                    cmp_vld_reg <= 1'b0;
                    if (win_on)
                    begin
                        ptr_reg                      <= ptr_next;
                        slot_vld_reg[ptr_next[IW-1:0]] <= 1'b1;
                        state_reg                    <= B_SCAN;
                    end
                    else
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_SCAN:
                begin
                    cmp_vld_reg <= issue && (rd_idx_reg != ptr_reg);
                    if (issue)
                    begin
                        rd_vld_reg <= slot_vld_reg[rd_idx_reg[IW-1:0]];
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (cmp_vld_reg && rd_key == cur_key)
                    begin
                        dup_reg <= 1'b1;
                    end
                    if (!issue && !cmp_vld_reg)
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dup_reg   <= dup_reg;
                        out_hi_reg    <= hi_reg;
                        out_lo_reg    <= lo_reg;
                        out_len_reg   <= len_reg;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/md5_duplicate_packet_filter.sv
// top level of the md5 duplicate packet filter
//
// usage: packet bytes enter on the s_axis stream, one byte per transaction;
// s_axis_tlast marks the final byte, and s_axis_tuser with tlast ends a packet
// without adding a byte. one result transaction per packet leaves on m_axis:
// the md5 digest, the byte length and a duplicate flag in m_axis_tuser.
// the front takes one byte per cycle, but stalls at each 64-byte boundary and
// at packet end while it hands the full or padded block(s) to a two-entry
// block queue, and waits while that queue is full. the back hashes a block
// with a load, 64 rounds in the shared round unit and a chain add; the queue
// lets the front collect the next block while the back is still hashing.
// after the final block the back writes the ring slot and scans the window
// slots, one per cycle through the slot memory read port, then registers the
// result; with the window off it skips the slot write and the scan. reset
// clears the chain, counters, ring pointer and the slot valid bits (an
// invalid slot compares as all zero), so no clearing pass is needed; the
// window length register resets to 16. when m_axis_tready is low the result
// waits in the output register while the back goes on hashing the next
// packet's blocks.
module md5_duplicate_packet_filter
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // byte stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    input  logic         s_axis_tuser,   // [0] empty_packet
    // result stream out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // [63:0] digest_high, [127:64] digest_low,
                                         // [159:128] packet_length
    output logic         m_axis_tuser,   // [0] duplicate
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

`include "assert_macros.svh"

    logic [4:0]              window_reg;
    logic                    push;
    logic                    pop;
    md5f_pkg::job_t          push_job;
    md5f_pkg::job_t          head_job;
    md5f_pkg::queue_status_t q_status;
    logic [63:0]             res_hi;
    logic [63:0]             res_lo;
    logic [31:0]             res_len;

    // register file: window length only
    assign pready = 1'b1;
    assign prdata = (paddr == md5f_pkg::ADDR_WINDOW_LEN) ? {27'd0, window_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= md5f_pkg::WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == md5f_pkg::ADDR_WINDOW_LEN)
        begin
            window_reg <= pwdata[4:0];
        end
    end

    // front: byte collection and padding
    md5f_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_empty (s_axis_tuser),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // block queue decouples the two sides
    md5f_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // back: compression, slot ring and duplicate scan
    md5f_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_reg),
        .head_job      (head_job),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_dup       (m_axis_tuser),
        .out_hi        (res_hi),
        .out_lo        (res_lo),
        .out_len       (res_len)
    );

    assign m_axis_tdata = {res_len, res_lo, res_hi};

    // front must stop taking bytes while it pads the closing block
    `ASSERT_CLK(a_stall_after_last, clk, rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready,
        "byte accepted right after packet end")

    // queue can never report full and empty together
    `ASSERT_ALWAYS(a_queue_sane, clk, !(q_status.full && q_status.empty),
        "block queue full and empty at once")

    // no push into a full queue and no pop from an empty one
    `ASSERT_CLK(a_queue_flow, clk, rst_n,
        !(push && q_status.full) && !(pop && q_status.empty),
        "block queue overrun or underrun")

    // disabled window never flags a duplicate
    `ASSERT_CLK(a_no_dup_when_off, clk, rst_n,
        m_axis_tvalid && window_reg == 5'd0 |-> !m_axis_tuser,
        "duplicate flagged with window off")

endmodule
